@@ rtl/bss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

  localparam int WORD_BITS = 32;
  localparam int BIT_SEL_W = 5;
  localparam int CFG_W     = 6;
  localparam int OP_W      = 3;
  localparam int INDEX_W   = 11;
  localparam int POS_W     = 10;
  localparam int COUNT_W   = 11;

  localparam logic [CFG_W-1:0] WORDS_IN_USE_RESET = 6'd32;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  typedef logic [WORD_BITS-1:0] word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic start;
    logic modify;
    logic scan_eval;
    logic advance;
    logic clr_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic single_go;
    logic scan_go;
    logic clear_op;
    logic clr_last;
    logic scan_stop;
  } sts_t;

  function automatic logic [5:0] ones_in_word(input word_t v);
    word_t x;
    x = v - ((v >> 1) & 32'h5555_5555);
    x = (x & 32'h3333_3333) + ((x >> 2) & 32'h3333_3333);
    x = (x + (x >> 4)) & 32'h0f0f_0f0f;
    x = x + (x >> 8);
    x = x + (x >> 16);
    return x[5:0];
  endfunction

  // position of the lowest set bit; word must be nonzero
  function automatic logic [BIT_SEL_W-1:0] lowest_one(input word_t v);
    word_t m;
    logic [5:0] c;
    m = v | (32'd0 - v);
    c = ones_in_word(m);
    return BIT_SEL_W'(6'd32 - c);
  endfunction

endpackage

`default_nettype wire

@@ rtl/bss_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bss_req_if;
  logic                              valid;
  logic                              ready;
  logic [bss_pkg::OP_W-1:0]          operation;
  logic signed [bss_pkg::INDEX_W-1:0] index;

  modport source (output valid, output operation, output index, input ready);
  modport sink (input valid, input operation, input index, output ready);
endinterface

`default_nettype wire

@@ rtl/bss_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bss_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          was_set;
  logic                          found;
  logic [bss_pkg::POS_W-1:0]     position;
  logic [bss_pkg::COUNT_W-1:0]   member_count;
  logic                          range_error;

  modport source (output valid, output was_set, output found, output position,
                  output member_count, output range_error, input ready);
  modport sink (input valid, input was_set, input found, input position,
                input member_count, input range_error, output ready);
endinterface

`default_nettype wire

@@ rtl/bss_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bss_datapath #(
  parameter int MAX_WORDS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [bss_pkg::CFG_W-1:0]          cfg_wr_data,
  input  wire logic [bss_pkg::OP_W-1:0]           in_operation,
  input  wire logic signed [bss_pkg::INDEX_W-1:0] in_index,
  input  wire bss_pkg::cmd_t                      cmd,
  output bss_pkg::sts_t                           sts,
  output logic                                    out_was_set,
  output logic                                    out_found,
  output logic [bss_pkg::POS_W-1:0]               out_position,
  output logic [bss_pkg::COUNT_W-1:0]             out_member_count,
  output logic                                    out_range_error
);

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  bss_pkg::word_t mem [MAX_WORDS];

  logic [bss_pkg::CFG_W-1:0]           words_in_use;
  logic [AW-1:0]                       clr_addr;
  logic [bss_pkg::OP_W-1:0]            op;
  logic signed [bss_pkg::INDEX_W-1:0]  index;
  logic [5:0]                          dnum;
  logic [bss_pkg::BIT_SEL_W-1:0]       bit_sel;
  logic                                first;
  bss_pkg::word_t                      rd_data;
  logic                                pend_was_set;
  logic                                pend_found;
  logic [bss_pkg::POS_W-1:0]           pend_position;
  logic [bss_pkg::COUNT_W-1:0]         pend_count;
  logic                                pend_err;

  logic [5:0]                          n;
  logic                                is_single;
  logic                                range_err;
  logic [11:0]                         start;
  logic                                is_find;
  logic                                find_ok;
  logic                                count_ok;
  logic [5:0]                          start_word;
  logic [bss_pkg::BIT_SEL_W-1:0]       start_bit;
  bss_pkg::word_t                      masked;
  logic                                hit;
  logic                                last;
  bss_pkg::word_t                      bit_mask;
  bss_pkg::word_t                      new_word;
  logic                                we;
  logic [AW-1:0]                       waddr;
  bss_pkg::word_t                      wdata;
  logic                                re;
  logic [AW-1:0]                       raddr;

  always_comb begin
    n = (int'(words_in_use) > MAX_WORDS) ? 6'(MAX_WORDS) : words_in_use;
    is_single = (op == bss_pkg::OP_ADD) || (op == bss_pkg::OP_REMOVE) ||
                (op == bss_pkg::OP_TEST);
    range_err = is_single &&
                (index[10] || ({1'b0, index[9:0]} >= {n, 5'b00000}));
    start = {index[10], index} + 12'd1;
    is_find = (op == bss_pkg::OP_FIND);
    find_ok = is_find && !start[11] && (start[10:5] < n);
    count_ok = (op == bss_pkg::OP_COUNT) && (n != 6'd0);
    if (is_single) begin
      start_word = {1'b0, index[9:5]};
      start_bit  = index[4:0];
    end else if (is_find) begin
      start_word = start[10:5];
      start_bit  = start[4:0];
    end else begin
      start_word = 6'd0;
      start_bit  = '0;
    end

    // only the first word of a search drops the bits below the start
    masked = rd_data & (first ? (32'hffff_ffff << bit_sel) : 32'hffff_ffff);
    hit = |masked;
    last = ({1'b0, dnum} + 7'd1) >= {1'b0, n};

    bit_mask = 32'd1 << bit_sel;
    new_word = (op == bss_pkg::OP_ADD) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);

    we    = cmd.clr_step ||
            (cmd.modify && ((op == bss_pkg::OP_ADD) || (op == bss_pkg::OP_REMOVE)));
    waddr = cmd.clr_step ? clr_addr : AW'(dnum);
    wdata = cmd.clr_step ? '0 : new_word;
    re    = cmd.start || cmd.advance;
    raddr = cmd.start ? AW'(start_word) : AW'(dnum + 6'd1);

    sts.single_go = is_single && !range_err;
    sts.scan_go   = find_ok || count_ok;
    sts.clear_op  = (op == bss_pkg::OP_CLEAR);
    sts.clr_last  = (clr_addr == AW'(MAX_WORDS - 1));
    sts.scan_stop = last || (is_find && hit);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= bss_pkg::WORDS_IN_USE_RESET;
      clr_addr     <= '0;
    end else begin
      if (cfg_wr_en) begin
        words_in_use <= cfg_wr_data;
      end
      if (cmd.clr_step) begin
        clr_addr <= sts.clr_last ? '0 : clr_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op    <= in_operation;
      index <= in_index;
    end
    if (cmd.start) begin
      dnum          <= start_word;
      bit_sel       <= start_bit;
      first         <= 1'b1;
      pend_was_set  <= 1'b0;
      pend_found    <= 1'b0;
      pend_position <= '0;
      pend_count    <= '0;
      pend_err      <= range_err;
    end
    if (cmd.modify) begin
      pend_was_set <= rd_data[bit_sel];
    end
    if (cmd.scan_eval) begin
      if (is_find && hit) begin
        pend_found    <= 1'b1;
        pend_position <= bss_pkg::POS_W'({dnum, bss_pkg::lowest_one(masked)});
      end
      if (op == bss_pkg::OP_COUNT) begin
        pend_count <= pend_count + bss_pkg::COUNT_W'(bss_pkg::ones_in_word(masked));
      end
    end
    if (cmd.advance) begin
      dnum  <= dnum + 6'd1;
      first <= 1'b0;
    end
    if (cmd.load_out) begin
      out_was_set      <= pend_was_set;
      out_found        <= pend_found;
      out_position     <= pend_position;
      out_member_count <= pend_count;
      out_range_error  <= pend_err;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bss_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire bss_pkg::sts_t sts,
  output bss_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_DECODE = 6'b000100,
    S_MODIFY = 6'b001000,
    S_SCAN   = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   clr_item;
  logic   clr_item_next;

  always_comb begin
    state_next    = state;
    clr_item_next = clr_item;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next    = clr_item ? S_FINISH : S_IDLE;
          clr_item_next = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.start = 1'b1;
        if (sts.single_go) begin
          state_next = S_MODIFY;
        end else if (sts.scan_go) begin
          state_next = S_SCAN;
        end else if (sts.clear_op) begin
          state_next    = S_CLEAR;
          clr_item_next = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_eval = 1'b1;
        if (sts.scan_stop) begin
          state_next = S_FINISH;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_item  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_item <= clr_item_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_set_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bit set of MAX_WORDS 32-bit words; cfg_wr_data sets how many words are in use.
// req carries one request (operation, index); rsp returns one result per request.
// Both channels move a transaction when valid and ready are high at a clock edge.
// One request is worked at a time; req.ready is high only while waiting for one.
// Steps from accept to rsp.valid:
//   add, remove, test: one word read, then a write-back for add and remove
//   find next: words scanned until a member or the last word
//   count: every word in use (one word popcounted per cycle from the memory port)
//   clear: all MAX_WORDS words (one word zeroed per cycle)
//   range errors and unknown codes: straight to the result, no scan or write
// The next request is accepted only once the block is back in the idle state.
// Reset (rst, synchronous) sets 32 words in use and starts a clearing pass over
// all MAX_WORDS words; req.ready stays low until it is done.
// Results sit in an output register; a stalled receiver holds the result there
// while the next request is accepted and worked, and only the hand-off waits.
module bitmap_set_store #(
  parameter int MAX_WORDS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [bss_pkg::CFG_W-1:0] cfg_wr_data,
  bss_req_if.sink                        req,
  bss_rsp_if.source                      rsp
);

  bss_pkg::cmd_t cmd;
  bss_pkg::sts_t sts;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bss_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_operation     (req.operation),
    .in_index         (req.index),
    .cmd              (cmd),
    .sts              (sts),
    .out_was_set      (rsp.was_set),
    .out_found        (rsp.found),
    .out_position     (rsp.position),
    .out_member_count (rsp.member_count),
    .out_range_error  (rsp.range_error)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_reset_clears_first: assert property (@(posedge clk)
    rst |=> !req.ready)
    else $error("request accepted before the clearing pass");

  a_error_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.range_error) |-> (!rsp.was_set && !rsp.found))
    else $error("range error with a bit result");

  a_find_no_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (rsp.member_count == '0))
    else $error("find result carries a member count");

endmodule

`default_nettype wire

@@ test/tb_bitmap_set_store.sv @@
`timescale 1ns / 1ps

module tb_bitmap_set_store;

  localparam logic [bss_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [bss_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int STORE_WORDS  = 32;
  localparam int SETTLE_TICKS = 48;
  localparam int PHASE_ITEMS  = 105;

  typedef struct packed {
    logic                        was_set;
    logic                        found;
    logic [bss_pkg::POS_W-1:0]   position;
    logic [bss_pkg::COUNT_W-1:0] member_count;
    logic                        range_error;
  } set_result_t;

  class bitmap_scoreboard;
    logic [bss_pkg::WORD_BITS-1:0] member_words [STORE_WORDS];
    logic [bss_pkg::CFG_W-1:0]     words_cfg;
    set_result_t                   awaited [$];
    int                            mismatches;

    function new();
      foreach (member_words[i]) member_words[i] = '0;
      words_cfg  = bss_pkg::WORDS_IN_USE_RESET;
      mismatches = 0;
    endfunction

    function void set_words(input logic [bss_pkg::CFG_W-1:0] v);
      words_cfg = v;
    endfunction

    function int active_words();
      return (words_cfg > STORE_WORDS) ? STORE_WORDS : int'(words_cfg);
    endfunction

    // Work out the result of one accepted request and advance the set.
    function void note_request(input logic [bss_pkg::OP_W-1:0] op,
                               input logic signed [bss_pkg::INDEX_W-1:0] idx);
      set_result_t                   r;
      int                            n, bit_total, at, w, sum;
      logic [bss_pkg::WORD_BITS-1:0] v;
      r         = '0;
      n         = active_words();
      bit_total = n * bss_pkg::WORD_BITS;
      at        = idx;
      case (op)
        bss_pkg::OP_ADD, bss_pkg::OP_REMOVE, bss_pkg::OP_TEST: begin
          if (at < 0 || at >= bit_total) begin
            r.range_error = 1'b1;
          end else begin
            w         = at / bss_pkg::WORD_BITS;
            r.was_set = member_words[w][at % bss_pkg::WORD_BITS];
            if (op == bss_pkg::OP_ADD)
              member_words[w][at % bss_pkg::WORD_BITS] = 1'b1;
            else if (op == bss_pkg::OP_REMOVE)
              member_words[w][at % bss_pkg::WORD_BITS] = 1'b0;
          end
        end
        bss_pkg::OP_FIND: begin
          at = at + 1;
          if (at >= 0 && at < bit_total) begin
            w = at / bss_pkg::WORD_BITS;
            v = member_words[w] & (32'hffff_ffff << (at % bss_pkg::WORD_BITS));
            while (v == '0 && w + 1 < n) begin
              w++;
              v = member_words[w];
            end
            if (v != '0) begin
              r.found = 1'b1;
              for (int k = bss_pkg::WORD_BITS - 1; k >= 0; k--)
                if (v[k]) r.position = bss_pkg::POS_W'(w * bss_pkg::WORD_BITS + k);
            end
          end
        end
        bss_pkg::OP_COUNT: begin
          sum = 0;
          for (int i = 0; i < n; i++) sum += $countones(member_words[i]);
          r.member_count = bss_pkg::COUNT_W'(sum);
        end
        bss_pkg::OP_CLEAR: begin
          foreach (member_words[i]) member_words[i] = '0;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(input set_result_t got);
      set_result_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: was_set=%0d found=%0d position=%0d count=%0d err=%0d",
                   got.was_set, got.found, got.position, got.member_count,
                   got.range_error);
        return;
      end
      exp = awaited.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected was_set=%0d found=%0d position=%0d count=%0d",
                    " err=%0d, got was_set=%0d found=%0d position=%0d count=%0d",
                    " err=%0d"},
                   exp.was_set, exp.found, exp.position, exp.member_count,
                   exp.range_error, got.was_set, got.found, got.position,
                   got.member_count, got.range_error);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_wr_en;
  logic [bss_pkg::CFG_W-1:0] cfg_wr_data;

  bss_req_if req_ch ();
  bss_rsp_if rsp_ch ();

  bitmap_set_store dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  bitmap_scoreboard sb;
  int req_idle_rate;
  int rsp_stall_rate;
  int rsp_stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_bitmap_set_store: done, errors");
    $finish;
  end

  // Result side: check each transaction, then stall in random bursts.
  initial begin
    rsp_ch.ready   <= 1'b0;
    rsp_stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        sb.check_result('{rsp_ch.was_set, rsp_ch.found, rsp_ch.position,
                          rsp_ch.member_count, rsp_ch.range_error});
      if (rsp_stall_left > 0) begin
        rsp_stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall_rate != 0 && $urandom_range(0, 15) < rsp_stall_rate) begin
        rsp_stall_left = $urandom_range(1, 14) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Hold valid until the transaction goes through; valid stays high afterwards.
  task automatic send_request(input logic [bss_pkg::OP_W-1:0] op, input int idx);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.index     <= bss_pkg::INDEX_W'(idx);
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(op, bss_pkg::INDEX_W'(idx));
  endtask

  task automatic maybe_gap();
    if (req_idle_rate != 0 && $urandom_range(0, 15) < req_idle_rate) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0 || req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_words(input logic [bss_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_words(v);
  endtask

  // Mostly in-range members, with the top edge, -1 and negatives mixed in.
  function automatic int pick_index(input int bit_total);
    int r, v;
    r = $urandom_range(0, 99);
    if (bit_total > 0 && r < 60) v = $urandom_range(0, bit_total - 1);
    else if (r < 70) v = bit_total - 1 + int'($urandom_range(0, 2));
    else if (r < 75) v = -1;
    else if (r < 80) v = -int'($urandom_range(2, 1024));
    else v = int'($urandom_range(0, 2047)) - 1024;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  function automatic logic [bss_pkg::OP_W-1:0] pick_operation();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return bss_pkg::OP_ADD;
    if (r < 45) return bss_pkg::OP_REMOVE;
    if (r < 63) return bss_pkg::OP_TEST;
    if (r < 85) return bss_pkg::OP_FIND;
    if (r < 92) return bss_pkg::OP_COUNT;
    if (r < 95) return bss_pkg::OP_CLEAR;
    return (r < 98) ? OP_SPARE_6 : OP_SPARE_7;
  endfunction

  task automatic send_random();
    send_request(pick_operation(), pick_index(sb.active_words() * bss_pkg::WORD_BITS));
    maybe_gap();
  endtask

  int phase_cfg [9];

  initial begin
    sb = new();
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    req_ch.valid <= 1'b0;
    req_ch.operation <= bss_pkg::OP_ADD;
    req_ch.index <= '0;
    req_idle_rate  = 0;
    rsp_stall_rate = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain_results();

    // directed: empty set, both ends of the index range, full scans
    send_request(bss_pkg::OP_COUNT, 0);
    send_request(bss_pkg::OP_FIND, -1);
    send_request(bss_pkg::OP_TEST, 0);
    send_request(bss_pkg::OP_ADD, 0);
    send_request(bss_pkg::OP_ADD, 0);
    send_request(bss_pkg::OP_ADD, 1023);
    send_request(bss_pkg::OP_ADD, 31);
    send_request(bss_pkg::OP_ADD, 32);
    send_request(bss_pkg::OP_TEST, 1023);
    send_request(bss_pkg::OP_FIND, -1);
    send_request(bss_pkg::OP_FIND, 0);
    send_request(bss_pkg::OP_FIND, 31);
    send_request(bss_pkg::OP_FIND, 32);
    send_request(bss_pkg::OP_FIND, 1023);
    send_request(bss_pkg::OP_FIND, -2);
    send_request(bss_pkg::OP_FIND, -1024);
    send_request(bss_pkg::OP_TEST, -1);
    send_request(bss_pkg::OP_ADD, -1024);
    send_request(bss_pkg::OP_REMOVE, 0);
    send_request(bss_pkg::OP_REMOVE, 0);
    send_request(bss_pkg::OP_COUNT, 0);
    send_request(OP_SPARE_6, 5);
    send_request(OP_SPARE_7, -1);
    send_request(bss_pkg::OP_CLEAR, 0);
    send_request(bss_pkg::OP_COUNT, 0);

    phase_cfg = '{1, 0, 63, 32, 7, 33, 0, 2, 32};
    phase_cfg[6] = $urandom_range(0, 63);
    foreach (phase_cfg[p]) begin
      write_words(bss_pkg::CFG_W'(phase_cfg[p]));
      if (p == 8) begin
        req_idle_rate  = 0;
        rsp_stall_rate = 0;
      end else begin
        req_idle_rate  = $urandom_range(0, 4);
        rsp_stall_rate = $urandom_range(0, 4);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off halfway through until every result is back
        if (i == PHASE_ITEMS / 2) drain_results();
        send_random();
      end
    end

    req_ch.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("tb_bitmap_set_store: done, clean");
    else
      $display("tb_bitmap_set_store: done, errors");
    $finish;
  end

endmodule
